[design/rcpg_pkg.sv]
// Shared types, constants and the CORDIC angle table for the rose curve point generator.
`timescale 1ns / 1ps
package rcpg_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_PETAL_FACTOR = 3'd0,
        CFG_RADIUS_SCALE = 3'd1,
        CFG_CENTER_X     = 3'd2,
        CFG_CENTER_Y     = 3'd3,
        CFG_PHASE_STEP   = 3'd4,
        CFG_POINT_COUNT  = 3'd5
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // CORDIC datapath widths
    localparam int XY_W   = 20;   // x/y working width, Q1.16 plus headroom
    localparam int Z_W    = 33;   // residual angle, signed Q0.32 turns
    localparam int TRIG_W = 19;   // signed cos/sin after quadrant fold

    localparam int ATAN_LEN = 24;

    localparam logic signed [XY_W-1:0] CORDIC_START = XY_W'(39797);

    // round(2^32 / 2pi)
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

    typedef logic signed [XY_W-1:0]   t_xy;
    typedef logic signed [Z_W-1:0]    t_z;
    typedef logic signed [TRIG_W-1:0] t_trig;

    // atan(2^-i) in Q0.32 turns
    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051D;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2E;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2F9;
            15: v = 32'h0000517C;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A2F;
            19: v = 32'h00000517;
            20: v = 32'h0000028B;
            21: v = 32'h00000145;
            22: v = 32'h000000A2;
            23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

[design/rcpg_cordic.sv]
// Pipelined rotation-mode CORDIC: phase in turns to Q1.16 cosine and sine.
`timescale 1ns / 1ps
module rcpg_cordic #(
    parameter int PHASE_BITS = 24,
    parameter int STAGES     = 16
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [PHASE_BITS-1:0]     i_phase,
    output rcpg_pkg::t_trig           o_cos,
    output rcpg_pkg::t_trig           o_sin
);
    import rcpg_pkg::*;

    logic [31:0] w_turn;
    t_z          w_z0;

    t_xy        r_x [1:STAGES];
    t_xy        r_y [1:STAGES];
    t_z         r_z [1:STAGES];
    logic [1:0] r_q [1:STAGES];

    t_trig r_cos;
    t_trig r_sin;
    t_trig w_x_ext;
    t_trig w_y_ext;

    // scale the phase to a Q0.32 turn; top two bits pick the quadrant
    assign w_turn = 32'(i_phase) << (32 - PHASE_BITS);
    assign w_z0   = t_z'({3'b000, w_turn[29:0]});

    // one micro-rotation per register stage
    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        t_xy        w_x;
        t_xy        w_y;
        t_z         w_z;
        logic [1:0] w_q;
        t_z         w_atan;

        if (i == 0) begin : g_first
            assign w_x = CORDIC_START;
            assign w_y = '0;
            assign w_z = w_z0;
            assign w_q = w_turn[31:30];
        end else begin : g_next
            assign w_x = r_x[i];
            assign w_y = r_y[i];
            assign w_z = r_z[i];
            assign w_q = r_q[i];
        end

        assign w_atan = t_z'({1'b0, atan_turn(i)});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_z >= 0) begin
                    r_x[i+1] <= w_x - (w_y >>> i);
                    r_y[i+1] <= w_y + (w_x >>> i);
                    r_z[i+1] <= w_z - w_atan;
                end else begin
                    r_x[i+1] <= w_x + (w_y >>> i);
                    r_y[i+1] <= w_y - (w_x >>> i);
                    r_z[i+1] <= w_z + w_atan;
                end
                r_q[i+1] <= w_q;
            end
        end
    end

    // quadrant fold
    assign w_x_ext = TRIG_W'(r_x[STAGES]);
    assign w_y_ext = TRIG_W'(r_y[STAGES]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_q[STAGES])
                2'd0: begin
                    r_cos <= w_x_ext;
                    r_sin <= w_y_ext;
                end
                2'd1: begin
                    r_cos <= -w_y_ext;
                    r_sin <= w_x_ext;
                end
                2'd2: begin
                    r_cos <= -w_x_ext;
                    r_sin <= -w_y_ext;
                end
                default: begin
                    r_cos <= w_y_ext;
                    r_sin <= -w_x_ext;
                end
            endcase
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

[design/rose_curve_point_generator.sv]
// Top level of the rose curve point generator: phase math, two CORDICs, radius and offset.
`timescale 1ns / 1ps
// Fully pipelined: one point is accepted and one produced every clock while the output
// is not stalled. An input beat passes the phase product and modulo-turn stages, the
// CORDIC stages plus its quadrant fold, then radius, offset product and center add. A
// stall on the output freezes the whole pipeline; o_ready is i_ready or an empty output slot.
// Configuration must be written only while the pipeline is empty.
module rose_curve_point_generator #(
    parameter int PHASE_BITS  = 24,
    parameter int TRIG_STAGES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [rcpg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rcpg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [7:0]                      i_point_index,
    input  logic [23:0]                     i_rot_angle,
    // output channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [11:0]              o_pixel_x,
    output logic signed [10:0]              o_pixel_y,
    output logic                            o_last_point
);
    import rcpg_pkg::*;

    localparam int NSTG = (TRIG_STAGES > ATAN_LEN) ? ATAN_LEN : TRIG_STAGES;
    localparam int LAT  = NSTG + 6;

    // configuration registers
    logic [3:0]  r_petal;
    logic [6:0]  r_scale;
    logic [10:0] r_cx;
    logic [9:0]  r_cy;
    logic [17:0] r_step;
    logic [7:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_petal <= 4'd5;
            r_scale <= 7'd50;
            r_cx    <= 11'd640;
            r_cy    <= 10'd360;
            r_step  <= 18'd83886;
            r_count <= 8'd100;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PETAL_FACTOR: r_petal <= i_cfg_data[3:0];
                CFG_RADIUS_SCALE: r_scale <= i_cfg_data[6:0];
                CFG_CENTER_X:     r_cx    <= i_cfg_data[10:0];
                CFG_CENTER_Y:     r_cy    <= i_cfg_data[9:0];
                CFG_PHASE_STEP:   r_step  <= i_cfg_data;
                CFG_POINT_COUNT:  r_count <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // global advance: move when the output slot is free or being taken
    logic w_en;
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    // valid and last-point flags travel alongside the data
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] r_last;
    logic           w_last_in;

    assign w_last_in = (i_point_index == (r_count - 8'd1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_last <= {r_last[LAT-2:0], w_last_in};
        end
    end

    // stage 1: position times step, angle times 1/2pi
    logic [24:0] w_pos;
    logic [42:0] r_prod_pos;
    logic [53:0] r_prod_ang;

    assign w_pos = {1'b0, i_point_index, 16'd0} + {1'b0, i_rot_angle};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod_pos <= 43'(w_pos) * 43'(r_step);
            r_prod_ang <= 54'(i_rot_angle) * 54'(INV_TWO_PI_Q32);
        end
    end

    // stage 2: petal phase and direction phase, modulo one turn
    logic [PHASE_BITS-1:0] w_phase;
    logic [PHASE_BITS-1:0] w_ang_turns;
    logic [PHASE_BITS+3:0] w_petal_full;
    logic [PHASE_BITS-1:0] r_petal_ph;
    logic [PHASE_BITS-1:0] r_dir_ph;

    assign w_phase      = r_prod_pos[40-PHASE_BITS +: PHASE_BITS];
    assign w_ang_turns  = r_prod_ang[48-PHASE_BITS +: PHASE_BITS];
    assign w_petal_full = (PHASE_BITS+4)'(r_petal) * (PHASE_BITS+4)'(w_phase);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_petal_ph <= w_petal_full[PHASE_BITS-1:0];
            r_dir_ph   <= w_phase + w_ang_turns;
        end
    end

    // sine/cosine pipelines
    t_trig w_cos_petal;
    t_trig w_sin_petal;
    t_trig w_cos_dir;
    t_trig w_sin_dir;

    rcpg_cordic #(.PHASE_BITS(PHASE_BITS), .STAGES(NSTG)) u_cordic_petal (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (r_petal_ph),
        .o_cos   (w_cos_petal),
        .o_sin   (w_sin_petal)
    );

    rcpg_cordic #(.PHASE_BITS(PHASE_BITS), .STAGES(NSTG)) u_cordic_dir (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (r_dir_ph),
        .o_cos   (w_cos_dir),
        .o_sin   (w_sin_dir)
    );

    // radius stage; petal cosine is not needed
    logic signed [26:0] r_rad;
    t_trig              r_cdir;
    t_trig              r_sdir;
    logic               w_unused_cos;

    assign w_unused_cos = ^w_cos_petal;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rad  <= 27'(signed'({1'b0, r_scale})) * 27'(w_sin_petal);
            r_cdir <= w_cos_dir;
            r_sdir <= w_sin_dir;
        end
    end

    // offset products, Q.32
    logic signed [45:0] r_offx;
    logic signed [45:0] r_offy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_offx <= 46'(r_rad) * 46'(r_cdir);
            r_offy <= 46'(r_rad) * 46'(r_sdir);
        end
    end

    // truncate toward zero, add center, wrap to output widths
    localparam logic signed [45:0] RND_NEG = 46'sd4294967295;

    logic signed [45:0] w_bx;
    logic signed [45:0] w_by;
    logic signed [13:0] w_tx;
    logic signed [13:0] w_ty;
    logic        [13:0] w_sx;
    logic        [13:0] w_sy;
    logic signed [11:0] r_px;
    logic signed [10:0] r_py;

    assign w_bx = r_offx[45] ? (r_offx + RND_NEG) : r_offx;
    assign w_by = r_offy[45] ? (r_offy + RND_NEG) : r_offy;
    assign w_tx = w_bx[45:32];
    assign w_ty = w_by[45:32];
    assign w_sx = w_tx + {3'b000, r_cx};
    assign w_sy = w_ty + {4'b0000, r_cy};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_px <= w_sx[11:0] ^ {11'd0, w_unused_cos & 1'b0};
            r_py <= w_sy[10:0];
        end
    end

    assign o_valid      = r_vld[LAT-1];
    assign o_last_point = r_last[LAT-1];
    assign o_pixel_x    = r_px;
    assign o_pixel_y    = r_py;

endmodule

[design/rcpg_checker.sv]
// Port-level checker for the rose curve point generator, bound to the top level.
`timescale 1ns / 1ps
module rcpg_port_sva (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [11:0] o_pixel_x,
    input logic signed [10:0] o_pixel_y,
    input logic               o_last_point
);

    // pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output beat valid right after reset");

    // an empty output slot never blocks the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while output slot empty");

    // a stalled output beat stays valid
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("output beat dropped while stalled");

    // a stalled output beat keeps its payload
    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=>
        $stable(o_pixel_x) && $stable(o_pixel_y) && $stable(o_last_point))
        else $error("output payload changed while stalled");

endmodule

bind rose_curve_point_generator rcpg_port_sva u_rcpg_port_sva (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_pixel_x    (o_pixel_x),
    .o_pixel_y    (o_pixel_y),
    .o_last_point (o_last_point)
);
